FILE: rtl/cv3_pkg.sv
`default_nettype none
package cv3_pkg;

    localparam int MAX_WIDTH  = 32768;
    localparam int KERNEL_DIM = 3;
    localparam int PIX_BITS   = 16;
    localparam int COEF_BITS  = 16;
    localparam int PROD_BITS  = PIX_BITS + COEF_BITS;
    localparam int ROW_BITS   = PROD_BITS + 2;
    localparam int RES_BITS   = 36;
    localparam int KROW_BITS  = KERNEL_DIM * COEF_BITS;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 16;
    localparam int CFG_BITS   = KROW_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int S_TDATA_BITS = ((PIX_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    typedef logic signed [PIX_BITS-1:0]  pix_t;
    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [ROW_BITS-1:0]  rsum_t;
    typedef logic signed [RES_BITS-1:0]  res_t;
    typedef logic [KROW_BITS-1:0]        krow_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_KERNEL_TOP = 3'd0,
        REG_KERNEL_MID = 3'd1,
        REG_KERNEL_BOT = 3'd2,
        REG_IMG_WIDTH  = 3'd3,
        REG_IMG_HEIGHT = 3'd4
    } cfg_reg_t;

    localparam krow_t KTOP_RESET = 48'hFF00_FF00_FF00;
    localparam krow_t KMID_RESET = 48'hFF00_0800_FF00;
    localparam krow_t KBOT_RESET = 48'hFF00_FF00_FF00;
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 16'd32768;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 16'd65535;
    localparam logic [DIM_BITS-1:0] DIM_MIN      = 16'd3;
    localparam logic [DIM_BITS-1:0] WIDTH_MAX    = DIM_BITS'(MAX_WIDTH);

    function automatic coef_t kernel_coef(input krow_t row, input int j);
        return coef_t'(row[j*COEF_BITS +: COEF_BITS]);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/cv3_line_ram.sv
`default_nettype none
module cv3_line_ram #(
    parameter int ADDR_BITS = 15,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/conv3x3_image_filter.sv
`default_nettype none
// 3x3 convolution over a raster pixel stream.
//
// Input beats on s_* carry one signed Q3.12 pixel each, in raster order.
// Output beats on m_* carry the exact signed Q.20 sum of the nine products
// for the centre pixel one row up and one column left; a beat is produced
// only for pixels at row two or later and column two or later, so border
// pixels give no result. m_tlast marks the result of the last pixel of a
// frame. Coefficients and image size come through the cfg_* write port;
// write it only while the block is idle, which the block does not enforce.
//
// Throughput is one pixel per clock while the receiver keeps up. The single
// line RAM (two rows packed in one word) is read when a pixel is accepted and
// written back as that pixel leaves stage 1, always at a different column
// than the pixel then accepted. A result beat passes the RAM read, multiply,
// row add and final add registers before it shows on m_tvalid.
// Reset clears the counters, the window and the pipeline valids and loads
// the default kernel and sizes; the line RAM is not cleared. When the
// receiver stalls, each stage holds its beat and bubbles collapse, so pixels
// are still taken until every stage is full.
module conv3x3_image_filter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [cv3_pkg::S_TDATA_BITS-1:0]    s_tdata,   // [15:0] pixel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [cv3_pkg::M_TDATA_BITS-1:0]    m_tdata,   // [35:0] filtered
    output logic                                     m_tlast,   // frame_last
    input  wire logic                                cfg_wr_en,
    input  wire logic [cv3_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [cv3_pkg::CFG_BITS-1:0]        cfg_data
);
    import cv3_pkg::*;

    // configuration
    krow_t               krow_reg [KERNEL_DIM];
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            krow_reg[0] <= KTOP_RESET;
            krow_reg[1] <= KMID_RESET;
            krow_reg[2] <= KBOT_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_KERNEL_TOP: krow_reg[0] <= cfg_data;
                REG_KERNEL_MID: krow_reg[1] <= cfg_data;
                REG_KERNEL_BOT: krow_reg[2] <= cfg_data;
                REG_IMG_WIDTH:  width_reg   <= cfg_data[DIM_BITS-1:0];
                REG_IMG_HEIGHT: height_reg  <= cfg_data[DIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes to the supported range
    logic [DIM_BITS-1:0] width_eff;
    logic [DIM_BITS-1:0] height_eff;

    always_comb begin
        if (width_reg < DIM_MIN) begin
            width_eff = DIM_MIN;
        end else if (width_reg > WIDTH_MAX) begin
            width_eff = WIDTH_MAX;
        end else begin
            width_eff = width_reg;
        end
        height_eff = (height_reg < DIM_MIN) ? DIM_MIN : height_reg;
    end

    // pipeline handshake: each stage moves when the next one is free or moving
    logic v1_reg, v2_reg, v3_reg, mv_reg;
    logic go1, go2, go3;
    logic accept;

    assign go3      = !mv_reg || m_tready;
    assign go2      = !v3_reg || go3;
    assign go1      = !v2_reg || go2;
    assign s_tready = !v1_reg || go1;
    assign accept   = s_tvalid && s_tready;

    // position counters, advanced on every accepted beat
    logic [COL_BITS-1:0] col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS:0]   row_inc;
    logic                produce;
    logic                last_pos;

    always_comb begin
        col_inc  = {{(DIM_BITS+1-COL_BITS){1'b0}}, col_reg} + 1'b1;
        row_inc  = {1'b0, row_reg} + 1'b1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_inc >= {1'b0, width_eff}) begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, height_eff}) ? '0 : row_inc[DIM_BITS-1:0];
            end else begin
                col_next = col_inc[COL_BITS-1:0];
            end
        end
        produce  = (row_reg >= 16'd2) && (col_reg >= COL_BITS'(2));
        last_pos = ({{(DIM_BITS-COL_BITS){1'b0}}, col_reg} == width_eff - 1'b1)
                && (row_reg == height_eff - 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: pixel waits here while the line RAM word for its column is read
    pix_t                pix1_reg;
    logic [COL_BITS-1:0] addr1_reg;
    logic                prod1_reg;
    logic                last1_reg;
    logic [2*PIX_BITS-1:0] ram_rd_data;
    logic                leave1;

    assign leave1 = v1_reg && go1;

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix1_reg  <= pix_t'(s_tdata[PIX_BITS-1:0]);
            addr1_reg <= col_reg;
            prod1_reg <= produce;
            last1_reg <= last_pos;
        end
    end

    // word layout: older row in the upper half, newer row in the lower half
    cv3_line_ram #(
        .ADDR_BITS (COL_BITS),
        .DATA_BITS (2*PIX_BITS)
    ) u_line_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data),
        .wr_en   (leave1),
        .wr_addr (addr1_reg),
        .wr_data ({ram_rd_data[PIX_BITS-1:0], pix1_reg})
    );

    // window column for the current pixel: older, newer, incoming
    pix_t col_pix [KERNEL_DIM];
    assign col_pix[0] = pix_t'(ram_rd_data[2*PIX_BITS-1:PIX_BITS]);
    assign col_pix[1] = pix_t'(ram_rd_data[PIX_BITS-1:0]);
    assign col_pix[2] = pix1_reg;

    // window: [i][0] holds column c-2, [i][1] column c-1
    pix_t win_reg [KERNEL_DIM][KERNEL_DIM-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KERNEL_DIM; i++) begin
                win_reg[i][0] <= '0;
                win_reg[i][1] <= '0;
            end
        end else if (leave1) begin
            for (int i = 0; i < KERNEL_DIM; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= col_pix[i];
            end
        end
    end

    // stage 2: nine products, one multiplier each
    prod_t prod_reg [KERNEL_DIM][KERNEL_DIM];
    logic  last2_reg;

    always_ff @(posedge aclk) begin
        if (go1) begin
            for (int i = 0; i < KERNEL_DIM; i++) begin
                prod_reg[i][0] <= win_reg[i][0] * kernel_coef(krow_reg[i], 0);
                prod_reg[i][1] <= win_reg[i][1] * kernel_coef(krow_reg[i], 1);
                prod_reg[i][2] <= col_pix[i]    * kernel_coef(krow_reg[i], 2);
            end
            last2_reg <= last1_reg;
        end
    end

    // stage 3: one sum per kernel row
    rsum_t rsum_reg [KERNEL_DIM];
    logic  last3_reg;

    always_ff @(posedge aclk) begin
        if (go2) begin
            for (int i = 0; i < KERNEL_DIM; i++) begin
                rsum_reg[i] <= rsum_t'(prod_reg[i][0]) + rsum_t'(prod_reg[i][1])
                             + rsum_t'(prod_reg[i][2]);
            end
            last3_reg <= last2_reg;
        end
    end

    // output register: final sum, held while the receiver stalls
    res_t res_reg;
    logic tlast_reg;

    always_ff @(posedge aclk) begin
        if (go3) begin
            res_reg   <= res_t'(rsum_reg[0]) + res_t'(rsum_reg[1]) + res_t'(rsum_reg[2]);
            tlast_reg <= last3_reg;
        end
    end

    // valids; beats of border pixels drop when they leave stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (s_tready) v1_reg <= s_tvalid;
            if (go1)      v2_reg <= v1_reg && prod1_reg;
            if (go2)      v3_reg <= v2_reg;
            if (go3)      mv_reg <= v3_reg;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(M_TDATA_BITS-RES_BITS){1'b0}}, res_reg};
    assign m_tlast  = tlast_reg;

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import cv3_pkg::*;

    // Stall watchdog: cycles in a row with no beat on either side and no write.
    localparam int IDLE_LIMIT    = 5000;
    // Settle time after the last result: the pipeline is four stages deep.
    localparam int DRAIN_CYCLES  = 8;
    // Length of the long receiver hold-off used to back up the pipeline.
    localparam int HOLD_CYCLES   = 300;
    localparam int PIXEL_TARGET  = 1800;

    typedef struct packed {
        res_t filtered;
        logic frame_last;
    } conv_beat_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [S_TDATA_BITS-1:0]       s_tdata   = '0;   // [15:0] pixel
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]       m_tdata;          // [35:0] filtered
    logic                          m_tlast;          // frame_last
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data  = '0;

    conv3x3_image_filter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers, line stores,
    // window and position counters. Stores and window are two-state so
    // entries never written read as zero.
    // ------------------------------------------------------------------
    krow_t                   kern [KERNEL_DIM] = '{KTOP_RESET, KMID_RESET, KBOT_RESET};
    logic [DIM_BITS-1:0]     cfg_width  = WIDTH_RESET;
    logic [DIM_BITS-1:0]     cfg_height = HEIGHT_RESET;
    bit signed [PIX_BITS-1:0] older_row [MAX_WIDTH];
    bit signed [PIX_BITS-1:0] newer_row [MAX_WIDTH];
    // Writes per column since reset, saturating at two; after two writes
    // both stored rows of that column hold real pixels.
    bit [1:0]                col_writes [MAX_WIDTH];
    bit signed [PIX_BITS-1:0] win [KERNEL_DIM][KERNEL_DIM-1];
    int                      col_cnt = 0;
    int                      row_cnt = 0;

    conv_beat_t              expected_q [$];
    conv_beat_t              want;

    // Stimulus plumbing between the initial block and the driver.
    pix_t                    pixel_q [$];
    pix_t                    batch [$];
    int                      pix_pushed   = 0;
    int                      pix_taken    = 0;
    int                      results_seen = 0;
    int                      mismatches   = 0;
    int                      tx_gap_max   = 0;
    int                      rx_gap_max   = 0;
    int                      hold_asks    = 0;

    logic                    in_fire  = 1'b0;
    logic                    out_fire = 1'b0;

    function automatic int eff_width(input logic [DIM_BITS-1:0] v);
        if (v < DIM_MIN)
            return int'(DIM_MIN);
        if (v > WIDTH_MAX)
            return MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic int eff_height(input logic [DIM_BITS-1:0] v);
        return (v < DIM_MIN) ? int'(DIM_MIN) : int'(v);
    endfunction

    // A new width is safe unless the rows above would be read at columns
    // that were never filled: any change is fine while still in row 0.
    function automatic bit width_fits(input int w);
        if (row_cnt == 0)
            return 1'b1;
        for (int c = 0; c < w; c++)
            if (col_writes[c] != 2'd2)
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the predictor by one pixel; queue the result it gives, if any.
    task automatic filter_pixel(input pix_t px);
        int         w;
        int         h;
        int         c;
        pix_t       taps [KERNEL_DIM];
        pix_t       tap;
        longint     acc;
        conv_beat_t beat;
        w = eff_width(cfg_width);
        h = eff_height(cfg_height);
        c = col_cnt % MAX_WIDTH;
        taps[0] = older_row[c];
        taps[1] = newer_row[c];
        taps[2] = px;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            acc = 0;
            for (int i = 0; i < KERNEL_DIM; i++) begin
                for (int j = 0; j < KERNEL_DIM; j++) begin
                    tap = (j < KERNEL_DIM - 1) ? pix_t'(win[i][j]) : taps[i];
                    acc += longint'(tap) *
                           longint'(coef_t'(kern[i][j*COEF_BITS +: COEF_BITS]));
                end
            end
            beat.filtered   = res_t'(acc);
            beat.frame_last = (row_cnt == h - 1) && (col_cnt == w - 1);
            expected_q.push_back(beat);
        end
        // Shift the window left and take the new column in on the right.
        for (int i = 0; i < KERNEL_DIM; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = taps[i];
        end
        older_row[c] = taps[1];
        newer_row[c] = taps[2];
        if (col_writes[c] != 2'd2)
            col_writes[c]++;
        col_cnt++;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= h)
                row_cnt = 0;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Sampling at the rising edge: track register writes, feed accepted
    // pixels to the predictor, check every accepted result beat.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_fire  <= aresetn && s_tvalid && s_tready;
        out_fire <= aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_KERNEL_TOP: kern[0] = cfg_data[KROW_BITS-1:0];
                    REG_KERNEL_MID: kern[1] = cfg_data[KROW_BITS-1:0];
                    REG_KERNEL_BOT: kern[2] = cfg_data[KROW_BITS-1:0];
                    REG_IMG_WIDTH:  cfg_width  = cfg_data[DIM_BITS-1:0];
                    REG_IMG_HEIGHT: cfg_height = cfg_data[DIM_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                filter_pixel(pix_t'(s_tdata[PIX_BITS-1:0]));
                pix_taken++;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                            results_seen));
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[RES_BITS-1:0] !== want.filtered)
                        flag_mismatch($sformatf("beat %0d filtered got %0d want %0d",
                                                results_seen,
                                                $signed(m_tdata[RES_BITS-1:0]),
                                                want.filtered));
                    if (m_tlast !== want.frame_last)
                        flag_mismatch($sformatf("beat %0d tlast got %b want %b",
                                                results_seen, m_tlast, want.frame_last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel driver: hold a beat until taken, then wait a drawn gap before
    // the next one. All changes land on the falling edge.
    // ------------------------------------------------------------------
    int tx_wait = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else if (!s_tvalid || in_fire) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (pixel_q.size() != 0) begin
                s_tdata  <= pixel_q.pop_front();
                s_tvalid <= 1'b1;
                tx_wait = $urandom_range(tx_gap_max, 0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: draw a stall per beat; on request, hold off for a
    // long stretch so the pipeline fills and backs up into s_tready.
    // ------------------------------------------------------------------
    int rx_wait    = 0;
    int hold_left  = 0;
    int holds_done = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_fire)
                rx_wait = $urandom_range(rx_gap_max, 0);
            if (holds_done != hold_asks) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long.
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers, all entered and left on a falling edge.
    // ------------------------------------------------------------------

    // Drive one register write; the caller drops cfg_wr_en after the last.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
    endtask

    // Wait for every pixel to be taken and every result to arrive, then
    // let the pipeline settle before touching the registers.
    task automatic wait_idle();
        while (pix_taken != pix_pushed || expected_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Hand the staged batch to the driver on a rising edge.
    task automatic launch_batch(input int tx_max, input int rx_max, input bit hold);
        @(posedge aclk);
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        foreach (batch[k])
            pixel_q.push_back(batch[k]);
        pix_pushed += batch.size();
        batch.delete();
        if (hold)
            hold_asks++;
        @(negedge aclk);
    endtask

    function automatic pix_t random_pixel();
        case ($urandom_range(0, 9))
            0:       return pix_t'(16'h8000);
            1:       return pix_t'(16'h7FFF);
            2:       return pix_t'(16'h0000);
            3:       return pix_t'(16'hFFFF);
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic krow_t random_krow();
        krow_t row;
        for (int j = 0; j < KERNEL_DIM; j++) begin
            case ($urandom_range(0, 5))
                0:       row[j*COEF_BITS +: COEF_BITS] = 16'h8000;
                1:       row[j*COEF_BITS +: COEF_BITS] = 16'h7FFF;
                2:       row[j*COEF_BITS +: COEF_BITS] = 16'h0100;
                default: row[j*COEF_BITS +: COEF_BITS] = 16'($urandom);
            endcase
        end
        return row;
    endfunction

    // Mostly small frames so frame ends come often; now and then a size
    // below the minimum or beyond the line store.
    function automatic logic [DIM_BITS-1:0] random_width();
        case ($urandom_range(0, 15))
            0:       return DIM_BITS'($urandom_range(0, 2));
            1:       return WIDTH_MAX;
            2:       return DIM_BITS'($urandom);
            3:       return '1;
            default: return DIM_BITS'($urandom_range(3, 12));
        endcase
    endfunction

    function automatic logic [DIM_BITS-1:0] random_height();
        case ($urandom_range(0, 15))
            0:       return DIM_BITS'($urandom_range(0, 2));
            1:       return '1;
            2:       return DIM_BITS'($urandom);
            default: return DIM_BITS'($urandom_range(3, 7));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int                  n;
        int                  phase;
        logic [DIM_BITS-1:0] wsel;

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Smallest frame with the power-on kernel: one result, flagged last.
        write_reg(REG_IMG_WIDTH, CFG_BITS'(DIM_MIN));
        write_reg(REG_IMG_HEIGHT, CFG_BITS'(DIM_MIN));
        cfg_wr_en <= 1'b0;
        batch = '{pix_t'(16'h7FFF), pix_t'(16'h8000), pix_t'(16'h0000),
                  pix_t'(16'hFFFF), pix_t'(16'h0001), pix_t'(16'h7FFF),
                  pix_t'(16'h8000), pix_t'(16'h5555), pix_t'(16'hAAAA)};
        launch_batch(3, 3, 1'b0);
        wait_idle();

        // Extreme coefficients and pixels; sizes below the minimum clamp to 3.
        write_reg(REG_KERNEL_TOP, 48'h8000_8000_8000);
        write_reg(REG_KERNEL_MID, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_KERNEL_BOT, 48'h7FFF_0000_8000);
        write_reg(REG_IMG_WIDTH, 48'd2);
        write_reg(REG_IMG_HEIGHT, 48'd0);
        cfg_wr_en <= 1'b0;
        batch = '{pix_t'(16'h8000), pix_t'(16'h8000), pix_t'(16'h8000),
                  pix_t'(16'h8000), pix_t'(16'h7FFF), pix_t'(16'h8000),
                  pix_t'(16'h8000), pix_t'(16'h8000), pix_t'(16'h7FFF)};
        launch_batch(0, 0, 1'b0);

        // Random phases. Each one starts idle, may rewrite any register,
        // often mid-frame, then streams a batch of pixels.
        phase = 0;
        while (pix_pushed < PIXEL_TARGET) begin
            wait_idle();
            if ($urandom_range(0, 1))
                write_reg(REG_KERNEL_TOP, random_krow());
            if ($urandom_range(0, 1))
                write_reg(REG_KERNEL_MID, random_krow());
            if ($urandom_range(0, 1))
                write_reg(REG_KERNEL_BOT, random_krow());
            if ($urandom_range(0, 4) != 0) begin
                // Keep the old width if the new one would read unfilled columns.
                wsel = random_width();
                if (!width_fits(eff_width(wsel)))
                    wsel = cfg_width;
                write_reg(REG_IMG_WIDTH, CFG_BITS'(wsel));
                write_reg(REG_IMG_HEIGHT, CFG_BITS'(random_height()));
            end
            if (phase % 10 == 3) begin
                // Narrow, tall frame: results come often and back up the pipeline.
                write_reg(REG_IMG_WIDTH, CFG_BITS'(DIM_MIN));
                write_reg(REG_IMG_HEIGHT, CFG_BITS'(HEIGHT_RESET));
            end
            cfg_wr_en <= 1'b0;
            n = (phase % 10 == 3) ? 100 : $urandom_range(20, 100);
            repeat (n) batch.push_back(random_pixel());
            if (phase % 10 == 3)
                launch_batch(0, 7, 1'b1);
            else
                launch_batch(($urandom_range(0, 3) == 0) ? 0 : 7,
                             ($urandom_range(0, 3) == 0) ? 0 : 7, 1'b0);
            phase++;
        end

        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
